[rtl/ttq_pkg.sv]
// ----------------------------------------------------------------------------
// ttq_pkg
// Types, codes and helpers shared by the timed task queue modules.
// ----------------------------------------------------------------------------
package ttq_pkg;

  localparam int TIME_WIDTH = 48;
  localparam int TASK_W     = 4;
  localparam int NUM_TASKS  = 16;
  localparam int PERIOD_W   = 32;
  localparam int MAX_OUT    = 16;
  localparam int PEND_AW    = $clog2(MAX_OUT);
  localparam int CNT_W      = PEND_AW + 1;

  localparam logic [31:0] IDLE_WAIT_RESET = 32'd5000000;

  // stream packing
  localparam int IN_TASK_LSB   = 0;
  localparam int IN_TIME_LSB   = TASK_W;
  localparam int IN_PER_LSB    = TASK_W + TIME_WIDTH;
  localparam int IN_DATA_RAW   = TASK_W + TIME_WIDTH + PERIOD_W;
  localparam int IN_DATA_W     = ((IN_DATA_RAW + 7) / 8) * 8;
  localparam int OUT_DATA_RAW  = TASK_W + TIME_WIDTH;
  localparam int OUT_DATA_W    = ((OUT_DATA_RAW + 7) / 8) * 8;

  // commands
  localparam logic [2:0] CMD_POST     = 3'd0;
  localparam logic [2:0] CMD_PERIODIC = 3'd1;
  localparam logic [2:0] CMD_CANCEL   = 3'd2;
  localparam logic [2:0] CMD_TICK     = 3'd3;
  localparam logic [2:0] CMD_STOP     = 3'd4;

  // result status
  localparam logic [2:0] ST_DUE       = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_POSTED    = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_POP,
    OP_CLEAR
  } chain_op_t;

  typedef struct packed {
    chain_op_t               op;
    logic [TASK_W-1:0]       id;
    logic [TIME_WIDTH-1:0]   due;
  } chain_ctl_t;

  typedef struct packed {
    logic                    valid;
    logic [TIME_WIDTH-1:0]   due;
    logic [TASK_W-1:0]       tid;
  } entry_t;

  // a + b, clamped at the largest time
  function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
                                                    input logic [PERIOD_W-1:0] b);
    logic [TIME_WIDTH:0] s;
    s = {1'b0, a} + {{(TIME_WIDTH + 1 - PERIOD_W){1'b0}}, b};
    return s[TIME_WIDTH] ? TIME_MAX : s[TIME_WIDTH-1:0];
  endfunction

  function automatic logic [OUT_DATA_W-1:0] pack_out(input logic [TASK_W-1:0] t,
                                                     input logic [TIME_WIDTH-1:0] tm);
    logic [OUT_DATA_W-1:0] d;
    d = '0;
    d[TASK_W-1:0] = t;
    d[TASK_W +: TIME_WIDTH] = tm;
    return d;
  endfunction

endpackage

[rtl/ttq_cell.sv]
// ----------------------------------------------------------------------------
// ttq_cell
// One slot of the sorted queue; trades its entry with left or right neighbor.
// ----------------------------------------------------------------------------
module ttq_cell import ttq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  chain_ctl_t ctl,
  input  entry_t     prev_ent,
  input  logic       prev_lt,
  input  logic       prev_hit,
  input  entry_t     next_ent,
  output entry_t     ent,
  output logic       lt,
  output logic       hit
);

  logic                  valid;
  logic [TIME_WIDTH-1:0] due;
  logic [TASK_W-1:0]     tid;

  assign ent = '{valid: valid, due: due, tid: tid};

  // entries strictly earlier than the new one stay put on insert
  assign lt  = valid && (due < ctl.due);
  // removal point is at or left of this cell
  assign hit = prev_hit || (ctl.op == OP_REMOVE && valid && tid == ctl.id);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_INSERT: begin
        if (!lt) begin
          if (prev_lt) begin
            due <= ctl.due;
            tid <= ctl.id;
          end else begin
            due <= prev_ent.due;
            tid <= prev_ent.tid;
          end
        end
      end
      OP_REMOVE, OP_POP: begin
        if (hit) begin
          due <= next_ent.due;
          tid <= next_ent.tid;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_INSERT: if (!lt) valid <= prev_lt || prev_ent.valid;
        OP_REMOVE, OP_POP: if (hit) valid <= next_ent.valid;
        OP_CLEAR: valid <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

[rtl/ttq_chain.sv]
// ----------------------------------------------------------------------------
// ttq_chain
// Row of queue cells kept sorted by due time, head in cell 0.
// ----------------------------------------------------------------------------
module ttq_chain import ttq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  chain_ctl_t ctl,
  output entry_t     ents [QUEUE_DEPTH],
  output logic       found
);

  logic lt  [QUEUE_DEPTH];
  logic hit [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t p_ent;
    entry_t n_ent;
    logic   p_lt;
    logic   p_hit;

    if (i == 0) begin : g_head
      assign p_ent = '0;
      assign p_lt  = 1'b1;
      // popping the head acts as a removal found before cell 0
      assign p_hit = (ctl.op == OP_POP);
    end else begin : g_mid
      assign p_ent = ents[i-1];
      assign p_lt  = lt[i-1];
      assign p_hit = hit[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign n_ent = '0;
    end else begin : g_body
      assign n_ent = ents[i+1];
    end

    ttq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .prev_ent (p_ent),
      .prev_lt  (p_lt),
      .prev_hit (p_hit),
      .next_ent (n_ent),
      .ent      (ents[i]),
      .lt       (lt[i]),
      .hit      (hit[i])
    );
  end

  assign found = hit[QUEUE_DEPTH-1];

endmodule

[rtl/timed_task_queue.sv]
// ----------------------------------------------------------------------------
// timed_task_queue
// Timer queue of task ids sorted by due time, with periodic reload.
// ----------------------------------------------------------------------------
// One command at a time. The queue is a row of cells that does one insert,
// remove or shift per cycle. Once the output is free, a result for a post,
// cancel or stop is registered in the execute state after the command is
// accepted, and for a tick in the pop state that follows. A cancel, stop,
// refused post or unknown code then returns to idle; an accepted post does
// its insert first. A tick pops each due task, then for each emitted task
// looks up its period, and re-queues a periodic one with an insert.
// A result that is not taken holds the next one back. The next command is
// accepted when the previous one has finished its queue updates.
module timed_task_queue import ttq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // slave stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // task_id, time_value, period, zero fill
  input  logic [2:0]            s_tuser,   // cmd
  // master stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // out_task, out_time, zero fill
  output logic [2:0]            m_tuser,   // status
  output logic                  m_tlast,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POST_INS,
    S_POP,
    S_RD,
    S_RINS
  } state_t;

  state_t                state;
  logic [2:0]            cmd_r;
  logic [TASK_W-1:0]     id_r;
  logic [TIME_WIDTH-1:0] time_r;
  logic [PERIOD_W-1:0]   per_r;
  logic [31:0]           idle_wait;

  logic [PERIOD_W-1:0]   per_tab  [NUM_TASKS];
  logic [NUM_TASKS-1:0]  periodic;

  logic [TASK_W-1:0]     pend_tid [MAX_OUT];
  logic [TIME_WIDTH-1:0] pend_due [MAX_OUT];
  logic [CNT_W-1:0]      pop_n;
  logic [CNT_W-1:0]      rcount;
  logic [TASK_W-1:0]     rins_id;
  logic [TIME_WIDTH-1:0] rins_due;

  chain_ctl_t            ctl;
  entry_t                ents [QUEUE_DEPTH];
  logic                  found;

  entry_t                head;
  entry_t                nxt;
  logic                  full;
  logic                  out_free;
  logic                  head_due;
  logic                  nxt_due;
  logic                  pop_last;
  logic [TIME_WIDTH-1:0] wake;
  logic                  cfg_wr;

  ttq_chain #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chain (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .ents  (ents),
    .found (found)
  );

  assign head     = ents[0];
  assign nxt      = ents[1];
  assign full     = ents[QUEUE_DEPTH-1].valid;
  assign out_free = !m_tvalid || m_tready;
  assign head_due = head.valid && (head.due <= time_r);
  assign nxt_due  = nxt.valid && (nxt.due <= time_r);
  assign pop_last = !((pop_n < CNT_W'(MAX_OUT - 1)) && nxt_due);
  assign wake     = head.valid ? head.due : sat_add(time_r, idle_wait);

  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = paddr[2] ? 32'd0 : idle_wait;

  always_comb begin
    ctl = '{op: OP_HOLD, id: id_r, due: time_r};
    unique case (state)
      S_EXEC: begin
        if (out_free) begin
          unique case (cmd_r)
            CMD_POST, CMD_PERIODIC, CMD_CANCEL: ctl.op = OP_REMOVE;
            CMD_STOP: ctl.op = OP_CLEAR;
            default: ;
          endcase
        end
      end
      S_POST_INS: ctl.op = OP_INSERT;
      S_POP: if (out_free && head_due) ctl.op = OP_POP;
      S_RINS: begin
        ctl.id  = rins_id;
        ctl.due = rins_due;
        if (!full) ctl.op = OP_INSERT;
      end
      default: ;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      cmd_r  <= s_tuser;
      id_r   <= s_tdata[IN_TASK_LSB +: TASK_W];
      time_r <= s_tdata[IN_TIME_LSB +: TIME_WIDTH];
      per_r  <= s_tdata[IN_PER_LSB +: PERIOD_W];
    end
    if (state == S_EXEC && out_free && cmd_r == CMD_PERIODIC && (found || !full)) begin
      per_tab[id_r] <= per_r;
    end
    if (state == S_POP && out_free && head_due) begin
      pend_tid[pop_n[PEND_AW-1:0]] <= head.tid;
      pend_due[pop_n[PEND_AW-1:0]] <= head.due;
    end
    if (state == S_RD && rcount != '0) begin
      for (int i = 0; i < MAX_OUT - 1; i++) begin
        pend_tid[i] <= pend_tid[i+1];
        pend_due[i] <= pend_due[i+1];
      end
      rins_id  <= pend_tid[0];
      rins_due <= sat_add(pend_due[0], per_tab[pend_tid[0]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      m_tdata   <= '0;
      m_tuser   <= ST_DUE;
      m_tlast   <= 1'b0;
      periodic  <= '0;
      idle_wait <= IDLE_WAIT_RESET;
      pop_n     <= '0;
      rcount    <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cfg_wr && !paddr[2]) idle_wait <= pwdata;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            m_tlast <= 1'b1;
            unique case (cmd_r)
              CMD_POST, CMD_PERIODIC: begin
                m_tvalid <= 1'b1;
                m_tdata  <= pack_out(id_r, time_r);
                if (!found && full) begin
                  m_tuser <= ST_FULL;
                  state   <= S_IDLE;
                end else begin
                  m_tuser        <= ST_POSTED;
                  periodic[id_r] <= (cmd_r == CMD_PERIODIC);
                  state          <= S_POST_INS;
                end
              end
              CMD_CANCEL: begin
                m_tvalid <= 1'b1;
                m_tdata  <= pack_out(id_r, '0);
                m_tuser  <= found ? ST_CANCELLED : ST_NOT_FOUND;
                state    <= S_IDLE;
              end
              CMD_TICK: begin
                pop_n <= '0;
                state <= S_POP;
              end
              CMD_STOP: begin
                m_tvalid <= 1'b1;
                m_tdata  <= pack_out('0, '0);
                m_tuser  <= ST_CLEARED;
                state    <= S_IDLE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_POST_INS: state <= S_IDLE;
        S_POP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (head_due) begin
              m_tdata <= pack_out(head.tid, head.due);
              m_tuser <= ST_DUE;
              m_tlast <= pop_last;
              pop_n   <= pop_n + 1'b1;
              if (pop_last) begin
                rcount <= pop_n + 1'b1;
                state  <= S_RD;
              end
            end else begin
              // nothing due at all: report the wake time
              m_tdata <= pack_out('0, wake);
              m_tuser <= ST_IDLE;
              m_tlast <= 1'b1;
              state   <= S_IDLE;
            end
          end
        end
        S_RD: begin
          if (rcount == '0) begin
            state <= S_IDLE;
          end else begin
            rcount <= rcount - 1'b1;
            if (periodic[pend_tid[0]]) state <= S_RINS;
          end
        end
        S_RINS: state <= S_RD;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_bound: assert property (@(posedge clk) disable iff (rst)
    pop_n <= CNT_W'(MAX_OUT))
    else $error("more results than allowed in one tick");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    head.valid && nxt.valid |-> head.due <= nxt.due)
    else $error("queue head out of order");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    nxt.valid |-> head.valid)
    else $error("hole at queue head");

  a_stop_empties: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && out_free && cmd_r == CMD_STOP |=> !head.valid)
    else $error("queue not empty after stop");

  a_last_pop: assert property (@(posedge clk) disable iff (rst)
    state == S_POP && ctl.op == OP_POP && pop_last |=> state == S_RD && m_tlast)
    else $error("final due task did not end the tick");

endmodule
